FILE: src/sfd_pkg.sv
`timescale 1ns / 1ps
// Package for the serial frame decoder: shared widths, constants, register
// indexes and the result record. No dependencies.
package sfd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned POS_W     = 9;
   localparam int unsigned CSR_IDX_W = 1;

   // Bytes around the payload: header, command, length, checksum, tail.
   localparam logic [POS_W-1:0] MIN_FRAME_BYTES = POS_W'(5);
   localparam logic [POS_W-1:0] POS_MAX         = {POS_W{1'b1}};

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h55;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER = 1'b0,
      CSR_TAIL   = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } result_kind_type;

   typedef struct packed {
      result_kind_type   kind;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_ok;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] payload_length;
   } rsp_type;

endpackage

FILE: src/serial_frame_decoder.sv
`timescale 1ns / 1ps
// Top level of the serial frame decoder; instantiates sfd_parser and
// sfd_rsp_reg and uses sfd_pkg.
//
// Checks framed buffers (header, command, length L, L payload bytes,
// checksum = payload sum mod 256, tail) one request byte at a time; the
// last byte of each buffer carries req_buffer_end. Payload bytes are passed
// on as they arrive (not when the payload byte itself is marked last), and
// the marked byte yields one status response with frame_ok, and command
// and payload_length of a valid frame. Other bytes give no response. The
// block takes one request per cycle: a request lands in an input register,
// is decoded against the per-buffer state, and its response (if any) is
// written to an output register. Rate is one request per cycle while
// rsp_ready is high; a stalled response holds the input register, and
// further requests wait only once both registers are occupied. Write
// header_value (index 0) and tail_value (index 1) through csr_ only while
// no request is in flight; writes are always taken.
module serial_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sfd_pkg::BYTE_W-1:0]      req_rx_byte,
   input  logic                            req_buffer_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_result_kind,
   output logic [sfd_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic                            rsp_frame_ok,
   output logic [sfd_pkg::BYTE_W-1:0]      rsp_command,
   output logic [sfd_pkg::BYTE_W-1:0]      rsp_payload_length,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfd_pkg::BYTE_W-1:0]      csr_wdata
);

   // Configuration registers
   logic [sfd_pkg::BYTE_W-1:0] header_ff, header_in;
   logic [sfd_pkg::BYTE_W-1:0] tail_ff, tail_in;

   // Input register
   logic                       in_valid_ff, in_valid_in;
   logic [sfd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                       in_end_ff;

   logic             req_fire;
   logic             in_move;
   logic             out_free;
   logic             has_rsp;
   sfd_pkg::rsp_type rsp_next;
   sfd_pkg::rsp_type rsp_data;

   // Always take configuration writes; decode the index.
   assign csr_ready = 1'b1;

   always_comb begin
      header_in = header_ff;
      tail_in   = tail_ff;
      if (csr_valid) begin
         unique case (sfd_pkg::csr_index_type'(csr_index))
            sfd_pkg::CSR_HEADER: header_in = csr_wdata;
            sfd_pkg::CSR_TAIL:   tail_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= sfd_pkg::HEADER_RESET;
         tail_ff   <= sfd_pkg::TAIL_RESET;
      end else begin
         header_ff <= header_in;
         tail_ff   <= tail_in;
      end
   end

   // Advance the held request whenever the result register can take it;
   // requests that produce no response simply drop out of the input stage.
   assign in_move     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || out_free;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !in_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold payload until the next request replaces it.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_rx_byte;
         in_end_ff  <= req_buffer_end;
      end
   end

   sfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (in_move),
      .rx_byte      (in_byte_ff),
      .buffer_end   (in_end_ff),
      .header_value (header_ff),
      .tail_value   (tail_ff),
      .has_rsp      (has_rsp),
      .rsp          (rsp_next)
   );

   sfd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (in_move && has_rsp),
      .load_data (rsp_next),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (out_free)
   );

   assign rsp_result_kind    = rsp_data.kind;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_frame_ok       = rsp_data.frame_ok;
   assign rsp_command        = rsp_data.command;
   assign rsp_payload_length = rsp_data.payload_length;

endmodule

FILE: src/sfd_parser.sv
`timescale 1ns / 1ps
// Frame parser: per-buffer state (position, held fields, running sum, match
// flags) and the decode of one byte into an optional result. Uses sfd_pkg.
module sfd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
   input  logic                        buffer_end,
   input  logic [sfd_pkg::BYTE_W-1:0]  header_value,
   input  logic [sfd_pkg::BYTE_W-1:0]  tail_value,
   output logic                        has_rsp,
   output sfd_pkg::rsp_type            rsp
);

   logic [sfd_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [sfd_pkg::BYTE_W-1:0] cmd_ff, cmd_in;
   logic [sfd_pkg::BYTE_W-1:0] len_ff, len_in;
   logic [sfd_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic                       hdr_ok_ff, hdr_ok_in;
   logic                       cks_ok_ff, cks_ok_in;

   logic [sfd_pkg::POS_W-1:0]  len_ext;
   logic [sfd_pkg::POS_W-1:0]  cks_pos;
   logic [sfd_pkg::POS_W-1:0]  tail_pos;
   logic                       frame_ok;

   assign len_ext  = {1'b0, len_ff};
   assign cks_pos  = len_ext + sfd_pkg::POS_W'(3);
   assign tail_pos = len_ext + sfd_pkg::MIN_FRAME_BYTES - sfd_pkg::POS_W'(1);
   assign frame_ok = hdr_ok_ff && cks_ok_ff
                     && (pos_ff >= sfd_pkg::MIN_FRAME_BYTES - sfd_pkg::POS_W'(1))
                     && (pos_ff == tail_pos) && (rx_byte == tail_value);

   always_comb begin
      pos_in    = pos_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      hdr_ok_in = hdr_ok_ff;
      cks_ok_in = cks_ok_ff;
      has_rsp   = 1'b0;
      rsp       = '0;
      if (buffer_end) begin
         // Marked byte: report status, then clear for the next buffer.
         has_rsp            = 1'b1;
         rsp.kind           = sfd_pkg::KIND_STATUS;
         rsp.frame_ok       = frame_ok;
         rsp.command        = frame_ok ? cmd_ff : '0;
         rsp.payload_length = frame_ok ? len_ff : '0;
         pos_in             = '0;
         cmd_in             = '0;
         len_in             = '0;
         sum_in             = '0;
         hdr_ok_in          = 1'b0;
         cks_ok_in          = 1'b0;
      end else begin
         if (pos_ff != sfd_pkg::POS_MAX) begin
            pos_in = pos_ff + sfd_pkg::POS_W'(1);
         end
         if (pos_ff == sfd_pkg::POS_W'(0)) begin
            hdr_ok_in = (rx_byte == header_value);
         end else if (pos_ff == sfd_pkg::POS_W'(1)) begin
            cmd_in = rx_byte;
         end else if (pos_ff == sfd_pkg::POS_W'(2)) begin
            len_in = rx_byte;
         end else if (pos_ff < cks_pos) begin
            sum_in           = sum_ff + rx_byte;
            has_rsp          = 1'b1;
            rsp.kind         = sfd_pkg::KIND_PAYLOAD;
            rsp.payload_byte = rx_byte;
         end else if (pos_ff == cks_pos) begin
            cks_ok_in = (rx_byte == sum_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         cmd_ff    <= '0;
         len_ff    <= '0;
         sum_ff    <= '0;
         hdr_ok_ff <= 1'b0;
         cks_ok_ff <= 1'b0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         hdr_ok_ff <= hdr_ok_in;
         cks_ok_ff <= cks_ok_in;
      end
   end

endmodule

FILE: src/sfd_rsp_reg.sv
`timescale 1ns / 1ps
// Result register: holds one finished result until the consumer takes it
// and reports when it can be loaded. Uses sfd_pkg.
module sfd_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  sfd_pkg::rsp_type load_data,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output sfd_pkg::rsp_type rsp_data,
   output logic             free
);

   logic             valid_ff, valid_in;
   sfd_pkg::rsp_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule
